// ===== rtl/core/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared types and codes for the positional list engine
// Action and status codes, field widths, the cell command and FSM state.
// ----------------------------------------------------------------------------
package ple_pkg;

    // field widths of the list ports
    localparam int ACT_W  = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STS_W  = 2;
    localparam int FPOS_W = 6;
    localparam int LEN_W  = 7;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_AT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_HEAD = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_TAIL = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_AT   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SEARCH   = 3'd6;

    // status codes
    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd3;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // open a gap at the target slot and write the new value
        logic del;   // close the gap at the target slot
    } t_cell_cmd;

    // sequencer states
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

endpackage

// ===== rtl/core/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list of signed 32-bit values
// Insert / delete at head, tail or index, and first-position search, on a
// chain of cells that shift entries in parallel.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  in       | i_in_valid / o_in_ready   | i_action, i_position_in, i_value
//  out      | o_out_valid / i_out_ready | o_status, o_found, o_found_position,
//           |                           | o_length
//
//  Insert, delete and error results are registered at the accept edge, and a new beat
//  is accepted while a result waits, as long as the slot frees that edge.
//  A search on a non-empty list first loads the match flags at the accept edge,
//  then takes one step per level of the find tree before its result is registered.
//  One item is in work at a time. Synchronous active-low reset empties the list;
//  entries are not cleared. An output stall holds a finished search in its state.
//
module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ple_pkg::ACT_W-1:0]        i_action,
    input  logic [ple_pkg::POS_W-1:0]        i_position_in,
    input  logic signed [ple_pkg::VAL_W-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [ple_pkg::STS_W-1:0]        o_status,
    output logic                             o_found,
    output logic [ple_pkg::FPOS_W-1:0]       o_found_position,
    output logic [ple_pkg::LEN_W-1:0]        o_length
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W  = ple_pkg::POS_W;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int STEP_W = $clog2(IDX_W + 1);
    localparam int FPOS_W = ple_pkg::FPOS_W;
    localparam int LEN_W  = ple_pkg::LEN_W;
    localparam logic [CNT_W-1:0]  CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [STEP_W-1:0] LEVELS  = STEP_W'(IDX_W);

    // sequencer and list length
    ple_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [STEP_W-1:0] r_steps, n_steps;

    // output register
    logic                      r_ovalid, n_ovalid;
    logic [ple_pkg::STS_W-1:0] r_status, n_status;
    logic                      r_found,  n_found;
    logic [FPOS_W-1:0]         r_fpos,   n_fpos;
    logic [LEN_W-1:0]          r_len,    n_len;

    // decode of the incoming beat
    logic                      in_accept;
    logic                      slot_free;
    logic                      list_full;
    logic                      list_empty;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          cnt_ext;
    logic [ple_pkg::STS_W-1:0] dec_status;
    ple_pkg::t_cell_cmd        dec_cmd;
    logic [IDX_W-1:0]          dec_pos;
    logic [CNT_W-1:0]          dec_count;
    logic                      dec_search;

    // chain and finder
    ple_pkg::t_cell_cmd               cell_cmd;
    logic signed [ple_pkg::VAL_W-1:0] w_value [CAPACITY];
    logic [CAPACITY-1:0]              w_match;
    logic                             find_load;
    logic                             find_step;
    logic                             find_found;
    logic [IDX_W-1:0]                 find_index;

    assign slot_free  = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == ple_pkg::S_IDLE) && slot_free;
    assign in_accept  = i_in_valid && o_in_ready;

    assign list_full  = (r_count == CAP_CNT);
    assign list_empty = (r_count == '0);
    assign pos_ext    = CMP_W'(i_position_in);
    assign cnt_ext    = CMP_W'(r_count);

    // action decoder: status, cell command, target slot, new length
    always_comb begin
        dec_status = ple_pkg::ST_OK;
        dec_cmd    = '0;
        dec_pos    = '0;
        dec_count  = r_count;
        dec_search = 1'b0;
        unique case (i_action)
            ple_pkg::ACT_INS_HEAD: begin
                if (list_full) begin
                    dec_status = ple_pkg::ST_FULL;
                end else begin
                    dec_cmd.ins = 1'b1;
                    dec_count   = r_count + 1'b1;
                end
            end
            ple_pkg::ACT_INS_TAIL: begin
                if (list_full) begin
                    dec_status = ple_pkg::ST_FULL;
                end else begin
                    dec_cmd.ins = 1'b1;
                    dec_pos     = r_count[IDX_W-1:0];
                    dec_count   = r_count + 1'b1;
                end
            end
            ple_pkg::ACT_INS_AT: begin
                if (list_full) begin
                    dec_status = ple_pkg::ST_FULL;
                end else if (list_empty) begin
                    dec_cmd.ins = 1'b1;
                    dec_count   = r_count + 1'b1;
                end else if (pos_ext > cnt_ext) begin
                    dec_status = ple_pkg::ST_RANGE;
                end else begin
                    dec_cmd.ins = 1'b1;
                    dec_pos     = pos_ext[IDX_W-1:0];
                    dec_count   = r_count + 1'b1;
                end
            end
            ple_pkg::ACT_DEL_HEAD: begin
                if (list_empty) begin
                    dec_status = ple_pkg::ST_EMPTY;
                end else begin
                    dec_cmd.del = 1'b1;
                    dec_count   = r_count - 1'b1;
                end
            end
            ple_pkg::ACT_DEL_TAIL: begin
                if (list_empty) begin
                    dec_status = ple_pkg::ST_EMPTY;
                end else begin
                    dec_cmd.del = 1'b1;
                    dec_pos     = IDX_W'(r_count - 1'b1);
                    dec_count   = r_count - 1'b1;
                end
            end
            ple_pkg::ACT_DEL_AT: begin
                if (list_empty) begin
                    dec_status = ple_pkg::ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    dec_status = ple_pkg::ST_RANGE;
                end else begin
                    dec_cmd.del = 1'b1;
                    dec_pos     = pos_ext[IDX_W-1:0];
                    dec_count   = r_count - 1'b1;
                end
            end
            ple_pkg::ACT_SEARCH: begin
                if (list_empty) begin
                    dec_status = ple_pkg::ST_EMPTY;
                end else begin
                    dec_search = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ple_pkg::S_IDLE: begin
                if (in_accept && dec_search) begin
                    n_state = ple_pkg::S_SCAN;
                end
            end
            ple_pkg::S_SCAN: begin
                if ((r_steps == '0) && slot_free) begin
                    n_state = ple_pkg::S_IDLE;
                end
            end
        endcase
    end

    // sequencer outputs, length and result register
    always_comb begin
        cell_cmd  = in_accept ? dec_cmd : '0;
        find_load = in_accept && dec_search;
        find_step = (r_state == ple_pkg::S_SCAN) && (r_steps != '0);
        n_count   = in_accept ? dec_count : r_count;
        n_steps   = r_steps;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_status  = r_status;
        n_found   = r_found;
        n_fpos    = r_fpos;
        n_len     = r_len;
        unique case (r_state)
            ple_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (dec_search) begin
                        n_steps = LEVELS;
                    end else begin
                        n_ovalid = 1'b1;
                        n_status = dec_status;
                        n_found  = 1'b0;
                        n_fpos   = '0;
                        n_len    = LEN_W'(dec_count);
                    end
                end
            end
            ple_pkg::S_SCAN: begin
                if (r_steps != '0) begin
                    n_steps = r_steps - 1'b1;
                end else if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_status = ple_pkg::ST_OK;
                    n_found  = find_found;
                    n_fpos   = find_found ? FPOS_W'(find_index) : '0;
                    n_len    = LEN_W'(r_count);
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ple_pkg::S_IDLE;
            r_count  <= '0;
            r_steps  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_steps  <= n_steps;
            r_ovalid <= n_ovalid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_found  <= n_found;
        r_fpos   <= n_fpos;
        r_len    <= n_len;
    end

    // chain of cells, head at index 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [ple_pkg::VAL_W-1:0] w_left;
        logic signed [ple_pkg::VAL_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_value[g];
        end else begin : g_mid_r
            assign w_right = w_value[g+1];
        end

        ple_cell #(
            .INDEX (g),
            .IW    (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_pos   (dec_pos),
            .i_new   (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g])
        );

        // per-slot compare, live slots only
        assign w_match[g] = (w_value[g] == i_value) && (CNT_W'(g) < r_count);
    end

    ple_find #(
        .N (CAPACITY)
    ) u_find (
        .i_clk   (i_clk),
        .i_load  (find_load),
        .i_step  (find_step),
        .i_match (w_match),
        .o_found (find_found),
        .o_index (find_index)
    );

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_status;
    assign o_found          = r_found;
    assign o_found_position = r_fpos;
    assign o_length         = r_len;

`ifndef ASSERT_OFF
    // length never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("list length beyond capacity");

    // a successful insert grows the list by one
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && cell_cmd.ins) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the list");

    // no new beat is taken while a search is in the tree
    a_scan_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ple_pkg::S_SCAN) |-> !o_in_ready)
        else $error("beat accepted during search");

    // a hit only comes with an ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_status == ple_pkg::ST_OK))
        else $error("found with error status");

    // a miss reports position zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_found_position == '0))
        else $error("miss with non-zero position");
`endif

endmodule

// ===== rtl/core/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell: one slot of the list chain
// Holds one entry; on insert takes its left neighbour or the new value, on
// delete takes its right neighbour, else holds.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 6
) (
    input  logic                             i_clk,
    input  ple_pkg::t_cell_cmd               i_cmd,
    input  logic [IW-1:0]                    i_pos,
    input  logic signed [ple_pkg::VAL_W-1:0] i_new,
    input  logic signed [ple_pkg::VAL_W-1:0] i_left,
    input  logic signed [ple_pkg::VAL_W-1:0] i_right,
    output logic signed [ple_pkg::VAL_W-1:0] o_value
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic signed [ple_pkg::VAL_W-1:0] r_value;
    logic signed [ple_pkg::VAL_W-1:0] n_value;

    // slot update: shift right above the gap, shift left from the gap on
    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (MY_IDX > i_pos) begin
                n_value = i_left;
            end else if (MY_IDX == i_pos) begin
                n_value = i_new;
            end
        end else if (i_cmd.del) begin
            if (MY_IDX >= i_pos) begin
                n_value = i_right;
            end
        end
    end

    // entry storage, no reset: slots are read only after being written
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/core/ple_find.sv =====
// ----------------------------------------------------------------------------
// ple_find: first-match finder
// Folded registered tree: loads one match flag per slot, then halves the
// candidate set each step, keeping the lower index on a tie.
// ----------------------------------------------------------------------------
module ple_find #(
    parameter int N = 64
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic                  i_step,
    input  logic [N-1:0]          i_match,
    output logic                  o_found,
    output logic [$clog2(N)-1:0]  o_index
);

    localparam int LEVELS = $clog2(N);
    localparam int NP     = 1 << LEVELS;
    localparam int IW     = LEVELS;

    logic          r_fnd [NP];
    logic [IW-1:0] r_idx [NP];

    // load leaves, or fold pairs into the lower half
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NP; j++) begin
            if (i_load) begin
                r_fnd[j] <= (j < N) ? i_match[j] : 1'b0;
                r_idx[j] <= IW'(j);
            end else if (i_step) begin
                if (j < NP / 2) begin
                    r_fnd[j] <= r_fnd[2*j] | r_fnd[2*j+1];
                    r_idx[j] <= r_fnd[2*j] ? r_idx[2*j] : r_idx[2*j+1];
                end else begin
                    r_fnd[j] <= 1'b0;
                end
            end
        end
    end

    assign o_found = r_fnd[0];
    assign o_index = r_idx[0];

endmodule
